// File: hw/rtl/sucps_pkg.sv
// ----------------------------------------------------------------------------
// sucps_pkg: shared types and constants
// Capacity, index and count widths, status codes and the structs passed
// between the top level and the cells of the sorted set.
// ----------------------------------------------------------------------------
package sucps_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POINT_W  = 21;
	localparam int BYTES_W  = 32;
	localparam int RIDX_W   = 5;
	localparam int OCNT_W   = 6;

	typedef enum logic [0:0] {
		KIND_INSERT = 1'b0,
		KIND_READ   = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_INSERTED     = 3'd0,
		ST_DUPLICATE    = 3'd1,
		ST_FULL         = 3'd2,
		ST_READ_OK      = 3'd3,
		ST_OUT_OF_RANGE = 3'd4
	} status_t;

	typedef struct packed {
		logic [POINT_W-1:0] point;
		logic [BYTES_W-1:0] bytes;
	} entry_t;

	// Broadcast to every cell for one insert request
	typedef struct packed {
		logic       ins_en;
		entry_t     ent;
		logic [CNT_W-1:0] cnt;
	} bcast_t;

	// Compare result of one cell
	typedef struct packed {
		logic less;
		logic eq;
	} cell_flag_t;

endpackage

// File: hw/rtl/sucps_if.sv
// ----------------------------------------------------------------------------
// sucps_if: request and result channels
// Valid/ready channels carrying the request fields and the result fields.
// ----------------------------------------------------------------------------
interface sucps_req_if;
	logic        valid;
	logic        ready;
	logic [0:0]  kind;
	logic [20:0] code_point;
	logic [31:0] encoded_bytes;
	logic [4:0]  read_index;

	modport source (output valid, kind, code_point, encoded_bytes, read_index, input ready);
	modport sink (input valid, kind, code_point, encoded_bytes, read_index, output ready);
endinterface

interface sucps_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [20:0] entry_point;
	logic [31:0] entry_bytes;
	logic [5:0]  entry_count;

	modport source (output valid, status, entry_point, entry_bytes, entry_count, input ready);
	modport sink (input valid, status, entry_point, entry_bytes, entry_count, output ready);
endinterface

// File: hw/rtl/sorted_unique_code_point_set.sv
// ----------------------------------------------------------------------------
// sorted_unique_code_point_set: sorted set of distinct code points
// Keeps up to CAPACITY code points with their encoded bytes in ascending
// order in a chain of cells, with insert and indexed read requests.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: kind 0 inserts code_point/encoded_bytes, kind 1
//   reads the entry at read_index. rsp returns exactly one result per request
//   with status, the entry for a successful read, and the count held after.
//   Every cell compares its entry with the new point at once; in the same
//   cycle the cells at and above the insert position shift up one slot.
//   The result appears in the cycle after the request is taken; one request per
//   cycle is taken while each result is read, as compare and shift act at once.
//   The result sits in an output register; a new request is taken when that
//   register is empty or being read in the same cycle, so a stalled receiver
//   holds the result and stops the request side until the result is read.
//   Reset clears the count and the output valid; the entries themselves are
//   not cleared and are reached only below the count.
// ----------------------------------------------------------------------------
module sorted_unique_code_point_set
	import sucps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	sucps_req_if.sink   req,
	sucps_rsp_if.source rsp
);

	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	status_t            status_q;
	logic [POINT_W-1:0] point_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [OCNT_W-1:0]  count_q;

	bcast_t             bc;
	cell_flag_t         flags [CAPACITY];
	entry_t             ents  [CAPACITY];
	logic [CAPACITY-1:0] eq_vec;

	logic               take;
	logic               is_ins;
	logic               full;
	logic               dup;
	logic               rd_ok;
	logic [CNT_W-1:0]   cnt_next;
	status_t            status_d;
	entry_t             rd_ent;

	assign take   = req.valid && req.ready;
	assign is_ins = (kind_t'(req.kind) == KIND_INSERT);
	assign full   = (cnt_q == CNT_W'(CAPACITY));
	assign dup    = |eq_vec;
	assign rd_ok  = (32'(req.read_index) < 32'(cnt_q));

	assign bc.ins_en    = take && is_ins && !full && !dup;
	assign bc.ent.point = req.code_point;
	assign bc.ent.bytes = req.encoded_bytes;
	assign bc.cnt       = cnt_q;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic   prev_less;
			entry_t left_ent;
			if (gi == 0) begin : g_head
				assign prev_less = 1'b1;
				assign left_ent  = bc.ent;
			end else begin : g_link
				assign prev_less = flags[gi-1].less;
				assign left_ent  = ents[gi-1];
			end
			sucps_cell u_cell (
				.clk       (clk),
				.idx       (IDX_W'(gi)),
				.bc        (bc),
				.prev_less (prev_less),
				.left_ent  (left_ent),
				.flag      (flags[gi]),
				.ent       (ents[gi])
			);
			assign eq_vec[gi] = flags[gi].eq;
		end
	endgenerate

	assign rd_ent = ents[IDX_W'(req.read_index)];

	always_comb begin
		cnt_next = cnt_q;
		if (is_ins) begin
			if (full) begin
				status_d = ST_FULL;
			end else if (dup) begin
				status_d = ST_DUPLICATE;
			end else begin
				status_d = ST_INSERTED;
				cnt_next = cnt_q + CNT_W'(1);
			end
		end else if (rd_ok) begin
			status_d = ST_READ_OK;
		end else begin
			status_d = ST_OUT_OF_RANGE;
		end
	end

	assign req.ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				cnt_q       <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= status_d;
			count_q  <= OCNT_W'(cnt_next);
			if (status_d == ST_READ_OK) begin
				point_q <= rd_ent.point;
				bytes_q <= rd_ent.bytes;
			end else begin
				point_q <= '0;
				bytes_q <= '0;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.entry_point = point_q;
	assign rsp.entry_bytes = bytes_q;
	assign rsp.entry_count = count_q;

endmodule

// File: hw/rtl/sucps_cell.sv
// ----------------------------------------------------------------------------
// sucps_cell: one slot of the sorted chain
// Holds one entry, compares it with the broadcast point and, on insert,
// holds, takes the new entry, or takes its left neighbor's entry.
// ----------------------------------------------------------------------------
module sucps_cell
	import sucps_pkg::*;
(
	input  logic             clk,
	input  logic [IDX_W-1:0] idx,
	input  bcast_t           bc,
	input  logic             prev_less,
	input  entry_t           left_ent,
	output cell_flag_t       flag,
	output entry_t           ent
);

	entry_t ent_q;
	logic   occupied;

	assign occupied  = CNT_W'(idx) < bc.cnt;
	assign flag.less = occupied && (ent_q.point < bc.ent.point);
	assign flag.eq   = occupied && (ent_q.point == bc.ent.point);
	assign ent       = ent_q;

	// Entries below the new point hold; the first slot not below takes the
	// new entry; everything above moves up one slot.
	always_ff @(posedge clk) begin
		if (bc.ins_en && !flag.less) begin
			if (prev_less) begin
				ent_q <= bc.ent;
			end else begin
				ent_q <= left_ent;
			end
		end
	end

endmodule

// File: sim/tb_sorted_unique_code_point_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_unique_code_point_set: self-checking bench for the sorted set
// A directed list of requests is run first: empty reads, extreme points,
// duplicates and reads at and past the count. Random inserts and reads follow
// in PHASES phases with varied idle gaps. Each result is compared with the typed
// value of its directed row, or else with a copy of the set that is kept in step
// with the accepted requests. Both channels idle at random, the receiver holds
// off once for a long stretch, and the sender at times waits for all outstanding results.
// ----------------------------------------------------------------------------
module tb_sorted_unique_code_point_set;
	import sucps_pkg::*;

	typedef struct packed {
		kind_t              kind;
		logic [POINT_W-1:0] point;
		logic [BYTES_W-1:0] bytes;
		logic [RIDX_W-1:0]  index;
	} request_t;

	typedef struct packed {
		status_t            status;
		logic [POINT_W-1:0] point;
		logic [BYTES_W-1:0] bytes;
		logic [OCNT_W-1:0]  count;
	} result_t;

	typedef struct packed {
		request_t req;
		bit       typed;
		result_t  res;
	} dir_row_t;

	localparam int      DIR_ROWS   = 24;
	localparam int      RAND_ITEMS = 900;
	localparam int      PHASES     = 6;
	localparam int      MAX_GAP    = 11;
	localparam int      LONG_HOLD  = 80;
	localparam result_t PREDICTED  = '0;

	logic clk;
	logic arst_n;

	sucps_req_if req_ch ();
	sucps_rsp_if rsp_ch ();

	sorted_unique_code_point_set dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the set, updated on every accepted request
	logic [POINT_W-1:0] set_points [CAPACITY];
	logic [BYTES_W-1:0] set_bytes  [CAPACITY];
	int                 set_count = 0;

	result_t pending_results [$];
	int      failures        = 0;
	int      results_seen    = 0;
	int      requests_sent   = 0;
	int      status_hits [5] = '{0, 0, 0, 0, 0};
	int      req_max_gap     = MAX_GAP;
	int      rsp_max_gap     = MAX_GAP;
	int      rsp_hold_cycles = 0;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{'{KIND_READ,   21'h000000, 32'h0000_0000, 5'd0},  1'b1,
			'{ST_OUT_OF_RANGE, 21'h000000, 32'h0000_0000, 6'd0}},
		'{'{KIND_READ,   21'h1FFFFF, 32'hFFFF_FFFF, 5'd31}, 1'b1,
			'{ST_OUT_OF_RANGE, 21'h000000, 32'h0000_0000, 6'd0}},
		'{'{KIND_INSERT, 21'h1FFFFF, 32'hFFFF_FFFF, 5'd31}, 1'b1,
			'{ST_INSERTED,     21'h000000, 32'h0000_0000, 6'd1}},
		'{'{KIND_INSERT, 21'h000000, 32'h0000_0000, 5'd0},  1'b1,
			'{ST_INSERTED,     21'h000000, 32'h0000_0000, 6'd2}},
		'{'{KIND_READ,   21'h1FFFFF, 32'hFFFF_FFFF, 5'd0},  1'b1,
			'{ST_READ_OK,      21'h000000, 32'h0000_0000, 6'd2}},
		'{'{KIND_READ,   21'h000000, 32'h0000_0000, 5'd1},  1'b1,
			'{ST_READ_OK,      21'h1FFFFF, 32'hFFFF_FFFF, 6'd2}},
		'{'{KIND_READ,   21'h000000, 32'h0000_0000, 5'd2},  1'b1,
			'{ST_OUT_OF_RANGE, 21'h000000, 32'h0000_0000, 6'd2}},
		'{'{KIND_INSERT, 21'h1FFFFF, 32'h1234_5678, 5'd0},  1'b1,
			'{ST_DUPLICATE,    21'h000000, 32'h0000_0000, 6'd2}},
		'{'{KIND_INSERT, 21'h000000, 32'hA5A5_A5A5, 5'd31}, 1'b1,
			'{ST_DUPLICATE,    21'h000000, 32'h0000_0000, 6'd2}},
		'{'{KIND_READ,   21'h000000, 32'h0000_0000, 5'd1},  1'b1,
			'{ST_READ_OK,      21'h1FFFFF, 32'hFFFF_FFFF, 6'd2}},
		'{'{KIND_INSERT, 21'h000041, 32'h0000_0041, 5'd10}, 1'b0, PREDICTED},
		'{'{KIND_INSERT, 21'h10FFFF, 32'hBFBF_8FF4, 5'd0},  1'b0, PREDICTED},
		'{'{KIND_INSERT, 21'h0000E9, 32'h0000_A9C3, 5'd7},  1'b0, PREDICTED},
		'{'{KIND_INSERT, 21'h1FFFFE, 32'h5A5A_5A5A, 5'd21}, 1'b0, PREDICTED},
		'{'{KIND_INSERT, 21'h000001, 32'h8080_8080, 5'd3},  1'b0, PREDICTED},
		'{'{KIND_INSERT, 21'h000041, 32'h0000_0000, 5'd0},  1'b0, PREDICTED},
		'{'{KIND_READ,   21'h1FFFFF, 32'hFFFF_FFFF, 5'd0},  1'b0, PREDICTED},
		'{'{KIND_READ,   21'h0AAAAA, 32'h5555_5555, 5'd1},  1'b0, PREDICTED},
		'{'{KIND_READ,   21'h155555, 32'hAAAA_AAAA, 5'd2},  1'b0, PREDICTED},
		'{'{KIND_READ,   21'h000000, 32'h0000_0000, 5'd3},  1'b0, PREDICTED},
		'{'{KIND_READ,   21'h000000, 32'h0000_0000, 5'd4},  1'b0, PREDICTED},
		'{'{KIND_READ,   21'h000000, 32'h0000_0000, 5'd5},  1'b0, PREDICTED},
		'{'{KIND_READ,   21'h000000, 32'h0000_0000, 5'd6},  1'b0, PREDICTED},
		'{'{KIND_READ,   21'h000000, 32'h0000_0000, 5'd7},  1'b0, PREDICTED}
	};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic result_t apply_to_set(request_t r);
		result_t res;
		int      pos;
		int      k;
		res = '0;
		if (r.kind == KIND_INSERT) begin
			if (set_count >= CAPACITY) begin
				res.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < set_count && set_points[pos] < r.point)
					pos++;
				if (pos < set_count && set_points[pos] == r.point) begin
					res.status = ST_DUPLICATE;
				end else begin
					// shift the tail up one slot to open the gap
					for (k = set_count; k > pos; k--) begin
						set_points[k] = set_points[k-1];
						set_bytes[k]  = set_bytes[k-1];
					end
					set_points[pos] = r.point;
					set_bytes[pos]  = r.bytes;
					set_count++;
					res.status = ST_INSERTED;
				end
			end
		end else if (int'(r.index) < set_count) begin
			res.status = ST_READ_OK;
			res.point  = set_points[r.index];
			res.bytes  = set_bytes[r.index];
		end else begin
			res.status = ST_OUT_OF_RANGE;
		end
		res.count = set_count[OCNT_W-1:0];
		return res;
	endfunction

	function automatic request_t random_request();
		request_t r;
		int       pick;
		r.kind  = ($urandom_range(0, 99) < ((set_count < CAPACITY) ? 50 : 30)) ?
			KIND_INSERT : KIND_READ;
		r.point = POINT_W'($urandom);
		r.bytes = $urandom;
		r.index = RIDX_W'($urandom);
		if (r.kind == KIND_INSERT) begin
			pick = $urandom_range(0, 9);
			if (pick <= 2 && set_count > 0) begin
				r.point = set_points[$urandom_range(0, set_count - 1)];
				// land next to a held point now and then
				if (pick == 2)
					r.point = $urandom_range(0, 1) ? r.point + 1'b1 : r.point - 1'b1;
			end else if (pick == 3) begin
				r.point = $urandom_range(0, 1) ? '1 : '0;
			end else if (pick == 4) begin
				r.point = POINT_W'($urandom_range(0, 255));
			end
		end else if ($urandom_range(0, 1) && set_count > 0) begin
			r.index = RIDX_W'($urandom_range(0, set_count - 1));
		end
		return r;
	endfunction

	task automatic send_request(request_t r, bit typed, result_t typed_res);
		int      gap;
		result_t res;
		gap = $urandom_range(0, req_max_gap);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.kind          <= r.kind;
		req_ch.code_point    <= r.point;
		req_ch.encoded_bytes <= r.bytes;
		req_ch.read_index    <= r.index;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		res = apply_to_set(r);
		pending_results.push_back(typed ? typed_res : res);
		requests_sent++;
	endtask

	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() > 0);
	endtask

	// Receiver: random stall before each result, plus one long hold-off
	initial begin
		int stall;
		stall = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				stall = $urandom_range(0, rsp_max_gap);
			else if (stall > 0)
				stall--;
			if (rsp_hold_cycles > 0) begin
				stall           = rsp_hold_cycles;
				rsp_hold_cycles = 0;
			end
			rsp_ch.ready <= (stall == 0);
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d count %0d",
					rsp_ch.status, rsp_ch.entry_count);
				failures++;
			end else begin
				want = pending_results.pop_front();
				status_hits[int'(want.status)]++;
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					failures++;
				end
				if (rsp_ch.entry_point !== want.point) begin
					$error("entry_point: expected %h, got %h", want.point, rsp_ch.entry_point);
					failures++;
				end
				if (rsp_ch.entry_bytes !== want.bytes) begin
					$error("entry_bytes: expected %h, got %h", want.bytes, rsp_ch.entry_bytes);
					failures++;
				end
				if (rsp_ch.entry_count !== want.count) begin
					$error("entry_count: expected %0d, got %0d", want.count, rsp_ch.entry_count);
					failures++;
				end
			end
		end
	end

	initial begin
		int phase;
		arst_n               <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.kind          <= KIND_INSERT;
		req_ch.code_point    <= '0;
		req_ch.encoded_bytes <= '0;
		req_ch.read_index    <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
		wait_for_results();

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					req_max_gap = MAX_GAP;
					rsp_max_gap = MAX_GAP;
				end
				1: begin
					// back-to-back requests against a stalled receiver
					req_max_gap     = 0;
					rsp_max_gap     = MAX_GAP;
					rsp_hold_cycles = LONG_HOLD;
				end
				2: begin
					req_max_gap = 0;
					rsp_max_gap = 0;
				end
				3: begin
					wait_for_results();
					req_max_gap = MAX_GAP;
					rsp_max_gap = 0;
				end
				4: begin
					req_max_gap = 3;
					rsp_max_gap = 3;
				end
				default: begin
					req_max_gap = MAX_GAP;
					rsp_max_gap = MAX_GAP;
				end
			endcase
			repeat (RAND_ITEMS / PHASES)
				send_request(random_request(), 1'b0, PREDICTED);
		end

		wait_for_results();
		repeat (10) @(posedge clk);

		$display("Sent %0d requests and checked %0d results; set ended with %0d entries.",
			requests_sent, results_seen, set_count);
		$display("Statuses: inserted %0d, duplicate %0d, full %0d, read %0d, out of range %0d.",
			status_hits[ST_INSERTED], status_hits[ST_DUPLICATE], status_hits[ST_FULL],
			status_hits[ST_READ_OK], status_hits[ST_OUT_OF_RANGE]);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/sucps_pkg.sv
hw/rtl/sucps_if.sv
hw/rtl/sucps_cell.sv
hw/rtl/sorted_unique_code_point_set.sv
sim/tb_sorted_unique_code_point_set.sv
